### rtl/core/rpc_pkg.sv
// rpc_pkg: shared types and constants of the raster primitive coverage block.
// Used by rpc_div, rpc_emit, rpc_cover and raster_primitive_coverage.
package rpc_pkg;

  // Field widths
  localparam int COORD_W = 10;
  localparam int THICK_W = 4;
  localparam int COLOR_W = 24;
  localparam int PRIM_W  = 3;

  // Signed working width for coordinates and differences
  localparam int CW      = COORD_W + 2;
  // Product width of the shared multiplier
  localparam int PROD_W  = 2 * CW;
  // Squared distance widths for the ring test
  localparam int SQ_W    = 2 * COORD_W;
  localparam int ACC_W   = SQ_W + 1;
  // Signed thick-line offset width
  localparam int KW      = THICK_W + 1;

  // Stream payload widths, padded to whole bytes
  localparam int IN_W    = ((2 * COORD_W + 7) / 8) * 8;
  localparam int OUT_RAW = 2 * COORD_W + COLOR_W;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

  // Defaults of the top-level parameters
  localparam int FRAME_WIDTH_DEF   = 1024;
  localparam int FRAME_HEIGHT_DEF  = 1024;
  localparam int MAX_THICKNESS_DEF = 15;

  typedef enum logic [PRIM_W-1:0] {
    PRIM_LINE  = 3'd0,
    PRIM_THICK = 3'd1,
    PRIM_RECT  = 3'd2,
    PRIM_FILL  = 3'd3,
    PRIM_RING  = 3'd4
  } prim_e;

  // Shape of the write pattern around a hit
  typedef enum logic [1:0] {
    KIND_GEN  = 2'd0,  // cross: row and column
    KIND_VERT = 2'd1,  // row only (vertical line widened sideways)
    KIND_HORZ = 2'd2   // column only
  } kind_e;

  typedef struct packed {
    logic [PRIM_W-1:0]  prim;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COORD_W-1:0] radius;
    logic [THICK_W-1:0] thickness;
    logic [COLOR_W-1:0] color;
  } cfg_t;

  // Write pattern request from the coverage sequencer to the emitter
  typedef struct packed {
    kind_e              kind;
    logic [THICK_W-1:0] thick;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } emit_req_t;

endpackage

### rtl/core/rpc_div.sv
// rpc_div: serial signed divider, one quotient bit per cycle, truncating.
// Depends on rpc_pkg. Quotient magnitude must stay below 2**COORD_W.
module rpc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [rpc_pkg::PROD_W-1:0] num_i,
  input  logic signed [rpc_pkg::CW-1:0]     den_i,
  output logic                              done_o,
  output logic signed [rpc_pkg::CW-1:0]     quot_o
);

  localparam int QW    = rpc_pkg::COORD_W;
  localparam int NW    = 2 * QW;
  localparam int CNT_W = $clog2(QW + 1);

  logic [rpc_pkg::PROD_W-1:0] num_mag;
  logic [rpc_pkg::CW-1:0]     den_mag;
  logic [QW:0]                trial;
  logic [QW:0]                diff;
  logic                       fits;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [QW-1:0]    rem_q;
  logic [QW-1:0]    low_q;
  logic [QW-1:0]    quo_q;
  logic [QW-1:0]    den_q;
  logic             neg_q;

  // Operand magnitudes
  assign num_mag = num_i[rpc_pkg::PROD_W-1] ? -num_i : num_i;
  assign den_mag = den_i[rpc_pkg::CW-1] ? -den_i : den_i;

  // Restoring step
  assign trial = {rem_q, low_q[QW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_mag[NW-1:QW];
      low_q <= num_mag[QW-1:0];
      den_q <= den_mag[QW-1:0];
      neg_q <= num_i[rpc_pkg::PROD_W-1] ^ den_i[rpc_pkg::CW-1];
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[QW-1:0] : trial[QW-1:0];
      low_q <= {low_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed({{(rpc_pkg::CW-QW){1'b0}}, quo_q})
                        : $signed({{(rpc_pkg::CW-QW){1'b0}}, quo_q});

endmodule

### rtl/core/rpc_emit.sv
// rpc_emit: expands one hit into its framebuffer writes, drops off-frame ones,
// holds one write back to flag the last, and drives the output register. Uses rpc_pkg.
module rpc_emit #(
  parameter int FRAME_WIDTH  = rpc_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = rpc_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  rpc_pkg::emit_req_t              req_i,
  input  logic [rpc_pkg::COLOR_W-1:0]     color_i,
  output logic                            idle_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: pixel_x [9:0], pixel_y [19:10], pixel_color [43:20], zero pad
  output logic [rpc_pkg::OUT_W-1:0]       m_axis_tdata,
  output logic                            m_axis_tlast
);

  localparam int CW    = rpc_pkg::CW;
  localparam int KW    = rpc_pkg::KW;
  localparam int TW    = rpc_pkg::THICK_W;
  localparam int PW    = rpc_pkg::COORD_W;
  localparam int SPAN  = 1 << PW;
  localparam int XLIM  = (FRAME_WIDTH < SPAN) ? FRAME_WIDTH : SPAN;
  localparam int YLIM  = (FRAME_HEIGHT < SPAN) ? FRAME_HEIGHT : SPAN;
  localparam int PAD_W = rpc_pkg::OUT_W - rpc_pkg::OUT_RAW;

  logic                gen_q;
  rpc_pkg::kind_e      kind_q;
  logic [TW-1:0]       t_q;
  logic signed [KW-1:0] k_q;
  logic                ph_q;
  logic [PW-1:0]       bx_q;
  logic [PW-1:0]       by_q;

  logic                pend_valid_q;
  logic [PW-1:0]       pend_x_q;
  logic [PW-1:0]       pend_y_q;

  logic                         out_valid_q;
  logic [PW-1:0]                out_x_q;
  logic [PW-1:0]                out_y_q;
  logic [rpc_pkg::COLOR_W-1:0]  out_color_q;
  logic                         out_last_q;

  logic signed [CW-1:0] kext;
  logic signed [CW-1:0] bxe;
  logic signed [CW-1:0] bye;
  logic signed [CW-1:0] cand_x;
  logic signed [CW-1:0] cand_y;
  logic                 use_x;
  logic                 cand_ok;
  logic                 last_step;
  logic                 to_ph1;
  logic                 out_free;
  logic                 can_take;
  logic                 advance;
  logic                 take;
  logic                 flush;
  logic                 out_load;
  logic                 out_load_last;

  // Candidate write for the current step
  assign kext   = {{(CW-KW){k_q[KW-1]}}, k_q};
  assign bxe    = $signed({{(CW-PW){1'b0}}, bx_q});
  assign bye    = $signed({{(CW-PW){1'b0}}, by_q});
  assign use_x  = !ph_q && (kind_q != rpc_pkg::KIND_HORZ);
  assign cand_x = use_x ? bxe + kext : bxe;
  assign cand_y = use_x ? bye : bye + kext;
  assign cand_ok = !cand_x[CW-1] && (cand_x < $signed(CW'(XLIM))) &&
                   !cand_y[CW-1] && (cand_y < $signed(CW'(YLIM)));

  // Step order: k from -t to t; on a cross, column write follows row write
  assign to_ph1    = (kind_q == rpc_pkg::KIND_GEN) && !ph_q && (k_q != '0);
  assign last_step = (k_q == $signed({1'b0, t_q})) && !to_ph1;

  // Handoff: pending write moves on when the output register frees up
  assign out_free      = !out_valid_q || m_axis_tready;
  assign can_take      = !pend_valid_q || out_free;
  assign advance       = gen_q && (!cand_ok || can_take);
  assign take          = advance && cand_ok;
  assign flush         = !gen_q && pend_valid_q && out_free;
  assign out_load      = (take && pend_valid_q) || flush;
  assign out_load_last = flush;

  assign idle_o = !gen_q && !pend_valid_q;

  // Sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q        <= 1'b0;
      ph_q         <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (start_i && idle_o) begin
        gen_q <= 1'b1;
        ph_q  <= 1'b0;
      end else if (advance) begin
        ph_q <= to_ph1;
        if (last_step) begin
          gen_q <= 1'b0;
        end
      end
      if (take) begin
        pend_valid_q <= 1'b1;
      end else if (flush) begin
        pend_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Step payload
  always_ff @(posedge clk_i) begin
    if (start_i && idle_o) begin
      kind_q <= req_i.kind;
      t_q    <= req_i.thick;
      k_q    <= -$signed({1'b0, req_i.thick});
      bx_q   <= req_i.x;
      by_q   <= req_i.y;
    end else if (advance && !to_ph1) begin
      k_q <= k_q + KW'(1);
    end
  end

  // Pending and output payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      pend_x_q <= cand_x[PW-1:0];
      pend_y_q <= cand_y[PW-1:0];
    end
    if (out_load) begin
      out_x_q     <= pend_x_q;
      out_y_q     <= pend_y_q;
      out_color_q <= color_i;
      out_last_q  <= out_load_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_color_q, out_y_q, out_x_q};

  // Offset stays inside -t..t while stepping
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_q |-> (k_q <= $signed({1'b0, t_q})) && (k_q >= -$signed({1'b0, t_q})))
    else $error("thick offset out of range");

  // Last write only goes out after the pattern is complete
  a_last_after_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_last |-> !gen_q && pend_valid_q)
    else $error("last write flagged while pattern still running");

  // Handing off the last write leaves the emitter idle
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_last |=> idle_o)
    else $error("emitter not idle after last write");

endmodule

### rtl/core/rpc_cover.sv
// rpc_cover: coverage sequencer. Tests one candidate pixel against the
// primitive using one shared multiplier and the serial divider rpc_div. Uses rpc_pkg.
module rpc_cover #(
  parameter int MAX_THICKNESS = rpc_pkg::MAX_THICKNESS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rpc_pkg::cfg_t                cfg_i,
  input  logic                         item_valid_i,
  output logic                         item_ready_o,
  input  logic [rpc_pkg::COORD_W-1:0]  item_x_i,
  input  logic [rpc_pkg::COORD_W-1:0]  item_y_i,
  output logic                         emit_start_o,
  output rpc_pkg::emit_req_t           emit_req_o,
  input  logic                         emit_idle_i
);

  localparam int CW  = rpc_pkg::CW;
  localparam int PW  = rpc_pkg::COORD_W;
  localparam int TW  = rpc_pkg::THICK_W;
  localparam int SW  = 4;

  localparam logic [SW-1:0] S_IDLE = 4'd0;
  localparam logic [SW-1:0] S_PRE  = 4'd1;
  localparam logic [SW-1:0] S_M1   = 4'd2;
  localparam logic [SW-1:0] S_D1S  = 4'd3;
  localparam logic [SW-1:0] S_D1W  = 4'd4;
  localparam logic [SW-1:0] S_M2   = 4'd5;
  localparam logic [SW-1:0] S_D2S  = 4'd6;
  localparam logic [SW-1:0] S_D2W  = 4'd7;
  localparam logic [SW-1:0] S_R1   = 4'd8;
  localparam logic [SW-1:0] S_R2   = 4'd9;
  localparam logic [SW-1:0] S_R3   = 4'd10;
  localparam logic [SW-1:0] S_R4   = 4'd11;
  localparam logic [SW-1:0] S_R5   = 4'd12;
  localparam logic [SW-1:0] S_EMIT = 4'd13;

  logic [SW-1:0] state_q, state_d;
  logic [PW-1:0] x_q, y_q;
  rpc_pkg::emit_req_t req_q, req_d;
  logic signed [rpc_pkg::PROD_W-1:0] mul_q, mul_d;
  logic signed [CW-1:0] mul_a, mul_b;
  logic [rpc_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [rpc_pkg::SQ_W-1:0]  rr_q, rr_d;

  logic                 div_start;
  logic                 div_done;
  logic signed [CW-1:0] div_den;
  logic signed [CW-1:0] quot;

  logic signed [CW-1:0] xe, ye, x0e, y0e, x1e, y1e, re, inner;
  logic signed [CW-1:0] dx, dy;
  logic [PW-1:0]        ylo, yhi;
  logic [TW-1:0]        t_clamp;
  logic                 vert_hit, horz_hit, pre_ok, rect_hit, fill_hit;

  // Working values
  assign xe    = $signed({2'b00, x_q});
  assign ye    = $signed({2'b00, y_q});
  assign x0e   = $signed({2'b00, cfg_i.start_x});
  assign y0e   = $signed({2'b00, cfg_i.start_y});
  assign x1e   = $signed({2'b00, cfg_i.end_x});
  assign y1e   = $signed({2'b00, cfg_i.end_y});
  assign re    = $signed({2'b00, cfg_i.radius});
  assign inner = re - $signed({{(CW-TW){1'b0}}, cfg_i.thickness});
  assign dx    = x1e - x0e;
  assign dy    = y1e - y0e;
  assign ylo   = (cfg_i.start_y < cfg_i.end_y) ? cfg_i.start_y : cfg_i.end_y;
  assign yhi   = (cfg_i.start_y < cfg_i.end_y) ? cfg_i.end_y : cfg_i.start_y;
  assign t_clamp = (cfg_i.thickness > TW'(MAX_THICKNESS)) ? TW'(MAX_THICKNESS)
                                                          : cfg_i.thickness;

  // Combinational tests
  assign vert_hit = (x_q == cfg_i.start_x) && (y_q >= cfg_i.start_y) &&
                    (y_q <= cfg_i.end_y);
  assign horz_hit = (y_q == cfg_i.start_y) && (x_q >= cfg_i.start_x) &&
                    (x_q <= cfg_i.end_x);
  assign pre_ok   = (x_q >= cfg_i.start_x) && (x_q <= cfg_i.end_x) &&
                    (y_q >= ylo) && (y_q <= yhi);
  assign rect_hit = ((x_q >= cfg_i.start_x) && (x_q <= cfg_i.end_x) &&
                     ((y_q == cfg_i.start_y) || (y_q == cfg_i.end_y))) ||
                    ((y_q >= cfg_i.start_y) && (y_q <= cfg_i.end_y) &&
                     ((x_q == cfg_i.start_x) || (x_q == cfg_i.end_x)));
  assign fill_hit = (x_q >= cfg_i.start_x) && (x_q <= cfg_i.end_x) &&
                    (y_q >= cfg_i.start_y) && (y_q <= cfg_i.end_y);

  // Shared multiplier, registered
  assign mul_d = mul_a * mul_b;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    acc_d        = acc_q;
    rr_d         = rr_q;
    mul_a        = dx;
    mul_b        = ye - y0e;
    div_start    = 1'b0;
    div_den      = dy;
    item_ready_o = 1'b0;
    emit_start_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          state_d = S_PRE;
        end
      end
      S_PRE: begin
        req_d.x     = x_q;
        req_d.y     = y_q;
        req_d.kind  = rpc_pkg::KIND_VERT;
        req_d.thick = (cfg_i.prim == rpc_pkg::PRIM_THICK) ? t_clamp : '0;
        state_d     = S_IDLE;
        unique case (cfg_i.prim)
          rpc_pkg::PRIM_LINE, rpc_pkg::PRIM_THICK: begin
            if (cfg_i.start_x == cfg_i.end_x) begin
              state_d = vert_hit ? S_EMIT : S_IDLE;
            end else if (cfg_i.start_y == cfg_i.end_y) begin
              req_d.kind = rpc_pkg::KIND_HORZ;
              state_d    = horz_hit ? S_EMIT : S_IDLE;
            end else begin
              req_d.kind = rpc_pkg::KIND_GEN;
              state_d    = pre_ok ? S_M1 : S_IDLE;
            end
          end
          rpc_pkg::PRIM_RECT: state_d = rect_hit ? S_EMIT : S_IDLE;
          rpc_pkg::PRIM_FILL: state_d = fill_hit ? S_EMIT : S_IDLE;
          rpc_pkg::PRIM_RING: state_d = S_R1;
          default:            state_d = S_IDLE;
        endcase
      end
      // Column test: x == dx*(y-y0)/dy + x0
      S_M1: state_d = S_D1S;
      S_D1S: begin
        div_start = 1'b1;
        state_d   = S_D1W;
      end
      S_D1W: begin
        if (div_done) begin
          state_d = (xe == quot + x0e) ? S_EMIT : S_M2;
        end
      end
      // Row test: y == dy*(x-x0)/dx + y0
      S_M2: begin
        mul_a   = dy;
        mul_b   = xe - x0e;
        state_d = S_D2S;
      end
      S_D2S: begin
        div_start = 1'b1;
        div_den   = dx;
        state_d   = S_D2W;
      end
      S_D2W: begin
        div_den = dx;
        if (div_done) begin
          state_d = (ye == quot + y0e) ? S_EMIT : S_IDLE;
        end
      end
      // Ring: squared distance against outer and inner squared radius
      S_R1: begin
        mul_a   = xe - x0e;
        mul_b   = xe - x0e;
        state_d = S_R2;
      end
      S_R2: begin
        acc_d   = mul_q[rpc_pkg::ACC_W-1:0];
        mul_a   = ye - y0e;
        mul_b   = ye - y0e;
        state_d = S_R3;
      end
      S_R3: begin
        acc_d   = acc_q + mul_q[rpc_pkg::ACC_W-1:0];
        mul_a   = re;
        mul_b   = re;
        state_d = S_R4;
      end
      S_R4: begin
        rr_d    = mul_q[rpc_pkg::SQ_W-1:0];
        mul_a   = inner;
        mul_b   = inner;
        state_d = S_R5;
      end
      S_R5: begin
        state_d = ((acc_q < {1'b0, rr_q}) &&
                   (acc_q >= {1'b0, mul_q[rpc_pkg::SQ_W-1:0]})) ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        emit_start_o = 1'b1;
        if (emit_idle_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_ready_o && item_valid_i) begin
      x_q <= item_x_i;
      y_q <= item_y_i;
    end
    req_q <= req_d;
    acc_q <= acc_d;
    rr_q  <= rr_d;
    mul_q <= mul_d;
  end

  assign emit_req_o = req_q;

  rpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_q),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

endmodule

### rtl/core/raster_primitive_coverage.sv
// raster_primitive_coverage: top level. APB register file, coverage sequencer
// and write emitter. Depends on rpc_pkg, rpc_cover, rpc_div and rpc_emit.
//
// Usage: program the primitive over the APB port (primitive, start/end corner,
// radius, thickness, color at byte addresses 0x00..0x1C), then stream candidate
// pixels on s_axis (one transaction per pixel). For every covered pixel the block
// sends its framebuffer writes on m_axis; tlast marks the final write of a pixel.
// Covered pixels of a thick line fan out into up to 4t+1 writes; writes outside
// the frame are dropped, and a pixel with no write produces no transaction.
// One candidate is tested at a time: s_axis takes the next one only after the
// current test ends. A sloped line inside its bounds runs the column test and, if
// that misses, the row test, each a product and a 10-step division through the
// serial divider.
// While m_axis is ready, writes leave at one per cycle as the next candidate is
// already being tested; a new pattern starts only when the previous one has left
// the holding stage. Each write waits there until the next write of its pattern
// is taken or the pattern ends, then moves into the output register; writes
// outside the frame are never held.
// A stalled m_axis holds the output register; the emitter and then s_axis stall
// behind it, and nothing is lost. Reset clears the configuration and the pipeline.
module raster_primitive_coverage #(
  parameter int FRAME_WIDTH   = rpc_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT  = rpc_pkg::FRAME_HEIGHT_DEF,
  parameter int MAX_THICKNESS = rpc_pkg::MAX_THICKNESS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // Candidate pixel stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: scan_x [9:0], scan_y [19:10], zero pad
  input  logic [rpc_pkg::IN_W-1:0]     s_axis_tdata,
  // Framebuffer write stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: pixel_x [9:0], pixel_y [19:10], pixel_color [43:20], zero pad
  output logic [rpc_pkg::OUT_W-1:0]    m_axis_tdata,
  // tlast: run_last
  output logic                         m_axis_tlast
);

  localparam int PW = rpc_pkg::COORD_W;

  // Register indexes
  localparam logic [2:0] REG_PRIM   = 3'd0;
  localparam logic [2:0] REG_SX     = 3'd1;
  localparam logic [2:0] REG_SY     = 3'd2;
  localparam logic [2:0] REG_EX     = 3'd3;
  localparam logic [2:0] REG_EY     = 3'd4;
  localparam logic [2:0] REG_RADIUS = 3'd5;
  localparam logic [2:0] REG_THICK  = 3'd6;
  localparam logic [2:0] REG_COLOR  = 3'd7;

  rpc_pkg::cfg_t      cfg_q;
  logic [2:0]         reg_idx;
  logic               wr_en;
  logic               emit_start;
  logic               emit_idle;
  rpc_pkg::emit_req_t emit_req;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PRIM:   cfg_q.prim      <= pwdata[rpc_pkg::PRIM_W-1:0];
        REG_SX:     cfg_q.start_x   <= pwdata[PW-1:0];
        REG_SY:     cfg_q.start_y   <= pwdata[PW-1:0];
        REG_EX:     cfg_q.end_x     <= pwdata[PW-1:0];
        REG_EY:     cfg_q.end_y     <= pwdata[PW-1:0];
        REG_RADIUS: cfg_q.radius    <= pwdata[PW-1:0];
        REG_THICK:  cfg_q.thickness <= pwdata[rpc_pkg::THICK_W-1:0];
        REG_COLOR:  cfg_q.color     <= pwdata[rpc_pkg::COLOR_W-1:0];
        default:    cfg_q           <= cfg_q;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      REG_PRIM:   prdata = 32'(cfg_q.prim);
      REG_SX:     prdata = 32'(cfg_q.start_x);
      REG_SY:     prdata = 32'(cfg_q.start_y);
      REG_EX:     prdata = 32'(cfg_q.end_x);
      REG_EY:     prdata = 32'(cfg_q.end_y);
      REG_RADIUS: prdata = 32'(cfg_q.radius);
      REG_THICK:  prdata = 32'(cfg_q.thickness);
      REG_COLOR:  prdata = 32'(cfg_q.color);
      default:    prdata = '0;
    endcase
  end

  rpc_cover #(
    .MAX_THICKNESS (MAX_THICKNESS)
  ) u_cover (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_x_i     (s_axis_tdata[PW-1:0]),
    .item_y_i     (s_axis_tdata[2*PW-1:PW]),
    .emit_start_o (emit_start),
    .emit_req_o   (emit_req),
    .emit_idle_i  (emit_idle)
  );

  rpc_emit #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (emit_start),
    .req_i         (emit_req),
    .color_i       (cfg_q.color),
    .idle_o        (emit_idle),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### tb/raster_primitive_coverage_test.sv
// raster_primitive_coverage_test: self-checking stream bench for the raster
// primitive coverage block. Depends on rpc_pkg and raster_primitive_coverage.
// Programs primitives over APB, streams candidate pixels, checks every write.
module raster_primitive_coverage_test;

  localparam int FRAME_W       = 1024;
  localparam int FRAME_H       = 1024;
  localparam int MAX_T         = 15;
  localparam int COORD_MAX     = 1023;
  localparam int DRAIN_CYCLES  = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int RUN_LIMIT     = 2_000_000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 25;
  localparam int MAX_PRINTED   = 50;

  // Register map, byte address is 4 * index
  typedef enum int {
    REG_PRIM, REG_START_X, REG_START_Y, REG_END_X, REG_END_Y,
    REG_RADIUS, REG_THICKNESS, REG_COLOR
  } reg_e;

  // Line coverage outcome, decides the thick-line write pattern
  typedef enum int {HIT_NONE, HIT_GEN, HIT_VERT, HIT_HORZ} hit_e;

  typedef struct {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [23:0] color;
    logic        last;
  } fb_write_t;

  // Shadow of the register file plus the queue of framebuffer writes still owed
  class pixel_write_board;
    int prim, sx, sy, ex, ey, radius, thick, color;
    fb_write_t pending_writes[$];
    int errors;
    int writes_seen;

    function void set_reg(reg_e idx, int value);
      case (idx)
        REG_PRIM:      prim   = value & 'h7;
        REG_START_X:   sx     = value & 'h3FF;
        REG_START_Y:   sy     = value & 'h3FF;
        REG_END_X:     ex     = value & 'h3FF;
        REG_END_Y:     ey     = value & 'h3FF;
        REG_RADIUS:    radius = value & 'h3FF;
        REG_THICKNESS: thick  = value & 'hF;
        REG_COLOR:     color  = value & 'hFFFFFF;
        default: ;
      endcase
    endfunction

    function hit_e line_hit(int x, int y);
      int dx, dy, ylo, yhi;
      if (sx == ex) return (x == sx && y >= sy && y <= ey) ? HIT_VERT : HIT_NONE;
      if (sy == ey) return (y == sy && x >= sx && x <= ex) ? HIT_HORZ : HIT_NONE;
      if (x < sx || x > ex) return HIT_NONE;
      ylo = (sy < ey) ? sy : ey;
      yhi = (sy < ey) ? ey : sy;
      if (y < ylo || y > yhi) return HIT_NONE;
      dx = ex - sx;
      dy = ey - sy;
      // signed divisions, truncating toward zero
      if (x == dx * (y - sy) / dy + sx || y == dy * (x - sx) / dx + sy) return HIT_GEN;
      return HIT_NONE;
    endfunction

    // Out-of-frame writes are dropped
    function void push_write(int x, int y);
      if (x < 0 || y < 0 || x >= FRAME_W || y >= FRAME_H || x > COORD_MAX || y > COORD_MAX)
        return;
      pending_writes.push_back('{x[9:0], y[9:0], color[23:0], 1'b0});
    endfunction

    // Predict the writes caused by one accepted candidate pixel
    function void note_candidate(int x, int y);
      hit_e kind;
      int base, t, k, d, inner;
      base = pending_writes.size();
      case (prim)
        rpc_pkg::PRIM_LINE: if (line_hit(x, y) != HIT_NONE) push_write(x, y);
        rpc_pkg::PRIM_THICK: begin
          kind = line_hit(x, y);
          t = (thick > MAX_T) ? MAX_T : thick;
          if (kind != HIT_NONE) begin
            for (k = -t; k <= t; k++) begin
              if (kind == HIT_VERT) begin
                push_write(x + k, y);
              end else if (kind == HIT_HORZ) begin
                push_write(x, y + k);
              end else begin
                // cross pattern, center once
                push_write(x + k, y);
                if (k != 0) push_write(x, y + k);
              end
            end
          end
        end
        rpc_pkg::PRIM_RECT: begin
          if ((x >= sx && x <= ex && (y == sy || y == ey)) ||
              (y >= sy && y <= ey && (x == sx || x == ex)))
            push_write(x, y);
        end
        rpc_pkg::PRIM_FILL: if (x >= sx && x <= ex && y >= sy && y <= ey) push_write(x, y);
        rpc_pkg::PRIM_RING: begin
          d = (x - sx) * (x - sx) + (y - sy) * (y - sy);
          inner = radius - thick;
          if (d < radius * radius && d >= inner * inner) push_write(x, y);
        end
        default: ;
      endcase
      if (pending_writes.size() > base) pending_writes[pending_writes.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_write(logic [9:0] x, logic [9:0] y, logic [23:0] c, logic last);
      fb_write_t want;
      writes_seen++;
      if (pending_writes.size() == 0) begin
        report($sformatf("unexpected write x=%0d y=%0d color=%06h last=%0b", x, y, c, last));
        return;
      end
      want = pending_writes.pop_front();
      if (x !== want.x || y !== want.y || c !== want.color || last !== want.last)
        report($sformatf("got x=%0d y=%0d color=%06h last=%0b, want x=%0d y=%0d color=%06h last=%0b",
                         x, y, c, last, want.x, want.y, want.color, want.last));
    endtask
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      psel, penable, pwrite;
  logic [4:0]                paddr;
  logic [31:0]               pwdata, prdata;
  logic                      pready;
  logic                      s_axis_tvalid, s_axis_tready;
  logic [rpc_pkg::IN_W-1:0]  s_axis_tdata;   // scan_x [9:0], scan_y [19:10], zero pad
  logic                      m_axis_tvalid, m_axis_tready;
  logic [rpc_pkg::OUT_W-1:0] m_axis_tdata;   // pixel_x [9:0], pixel_y [19:10], pixel_color [43:20]
  logic                      m_axis_tlast;   // run_last

  int  src_idle_pct, rx_idle_pct;
  bit  hold_req, hold_seen;
  int  hold_left;
  int  candidates_sent, setups;
  pixel_write_board board = new();

  raster_primitive_coverage dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 0;
  end

  // Write receiver: random back-pressure, or a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Transaction monitor on both streams
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        board.note_candidate(int'(s_axis_tdata[9:0]), int'(s_axis_tdata[19:10]));
        candidates_sent++;
      end
      if (m_axis_tvalid && m_axis_tready)
        board.check_write(m_axis_tdata[9:0], m_axis_tdata[19:10], m_axis_tdata[43:20],
                          m_axis_tlast);
    end
  end

  // Back-to-back APB transfers; psel is dropped by the caller
  task automatic write_reg(reg_e idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(int'(idx) * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.set_reg(idx, value);
  endtask

  task automatic setup_primitive(int prim, int sx, int sy, int ex, int ey,
                                 int r, int t, int c);
    write_reg(REG_PRIM, prim);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_END_X, ex);
    write_reg(REG_END_Y, ey);
    write_reg(REG_RADIUS, r);
    write_reg(REG_THICKNESS, t);
    write_reg(REG_COLOR, c);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    setups++;
  endtask

  // tvalid stays high across back-to-back items; only lowered for a gap
  task automatic send_pixel(int x, int y);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(rpc_pkg::IN_W - 20){1'b0}}, 10'(y), 10'(x)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Idle the input, wait for all writes, then cover candidates with no writes
  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_writes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(7))
      0: return 0;
      1: return COORD_MAX;
      default: return $urandom_range(COORD_MAX);
    endcase
  endfunction

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  // Mostly points on or next to the current primitive, some anywhere
  function automatic void pick_candidate(output int x, output int y);
    int xlo, xhi, ylo, yhi, dx, r;
    xlo = (board.sx < board.ex) ? board.sx : board.ex;
    xhi = (board.sx < board.ex) ? board.ex : board.sx;
    ylo = (board.sy < board.ey) ? board.sy : board.ey;
    yhi = (board.sy < board.ey) ? board.ey : board.sy;
    x = rand_coord();
    y = rand_coord();
    if ($urandom_range(4) == 0) return;
    case (board.prim)
      rpc_pkg::PRIM_LINE, rpc_pkg::PRIM_THICK: begin
        dx = board.ex - board.sx;
        x = $urandom_range(xhi, xlo);
        if (dx == 0) y = $urandom_range(yhi, ylo);
        else y = (board.ey - board.sy) * (x - board.sx) / dx + board.sy;
      end
      rpc_pkg::PRIM_RECT: begin
        if ($urandom_range(1) == 0) begin
          x = $urandom_range(xhi, xlo);
          y = ($urandom_range(1) == 0) ? board.sy : board.ey;
        end else begin
          y = $urandom_range(yhi, ylo);
          x = ($urandom_range(1) == 0) ? board.sx : board.ex;
        end
      end
      rpc_pkg::PRIM_FILL: begin
        x = $urandom_range(xhi, xlo);
        y = $urandom_range(yhi, ylo);
      end
      rpc_pkg::PRIM_RING: begin
        r = board.radius;
        x = board.sx + int'($urandom_range(2 * r + 2)) - r - 1;
        y = board.sy + int'($urandom_range(2 * r + 2)) - r - 1;
      end
      default: ;
    endcase
    if ($urandom_range(2) == 0) begin
      x += int'($urandom_range(4)) - 2;
      y += int'($urandom_range(4)) - 2;
    end
    x = clamp_coord(x);
    y = clamp_coord(y);
  endfunction

  task automatic random_setup(bit stress);
    int prim, sx, sy, ex, ey, r, t, c, swap;
    prim = ($urandom_range(9) == 0) ? $urandom_range(7, 5) : $urandom_range(4);
    sx = rand_coord();
    sy = rand_coord();
    ex = rand_coord();
    ey = rand_coord();
    // lines mostly run left to right; a few stay reversed
    if ((prim == rpc_pkg::PRIM_LINE || prim == rpc_pkg::PRIM_THICK) &&
        ex < sx && $urandom_range(5) != 0) begin
      swap = sx; sx = ex; ex = swap;
    end
    // rectangles mostly with ordered corners
    if ((prim == rpc_pkg::PRIM_RECT || prim == rpc_pkg::PRIM_FILL) &&
        $urandom_range(3) != 0) begin
      if (ex < sx) begin swap = sx; sx = ex; ex = swap; end
      if (ey < sy) begin swap = sy; sy = ey; ey = swap; end
    end
    case ($urandom_range(4))
      0: ex = sx;
      1: ey = sy;
      default: ;
    endcase
    r = ($urandom_range(3) == 0) ? rand_coord() : $urandom_range(60);
    case ($urandom_range(3))
      0: t = 0;
      1: t = MAX_T;
      default: t = $urandom_range(MAX_T);
    endcase
    case ($urandom_range(5))
      0: c = 0;
      1: c = 'hFFFFFF;
      default: c = $urandom_range('hFFFFFF);
    endcase
    // widest sloped thick line, so the output stall backs up into the input
    if (stress) begin
      prim = rpc_pkg::PRIM_THICK;
      t = MAX_T;
      sx = $urandom_range(400, 100);
      ex = sx + $urandom_range(300, 50);
      sy = $urandom_range(400, 100);
      ey = sy + $urandom_range(300, 20);
    end
    setup_primitive(prim, sx, sy, ex, ey, r, t, c);
  endtask

  task automatic directed_checks();
    // reset state: degenerate line at the origin
    send_pixel(0, 0);
    send_pixel(3, 7);
    finish_phase();
    // sloped thin line: both ends, an interior point, two misses
    setup_primitive(rpc_pkg::PRIM_LINE, 10, 20, 40, 90, 0, 0, 'hFFFFFF);
    send_pixel(10, 20);
    send_pixel(40, 90);
    send_pixel(25, 55);
    send_pixel(26, 20);
    send_pixel(41, 90);
    finish_phase();
    // thick vertical line on the left frame edge, clipped sideways
    setup_primitive(rpc_pkg::PRIM_THICK, 0, 0, 0, COORD_MAX, 0, MAX_T, 0);
    send_pixel(0, 0);
    send_pixel(0, COORD_MAX);
    finish_phase();
    // thick horizontal line on the top row, clipped upward
    setup_primitive(rpc_pkg::PRIM_THICK, 5, COORD_MAX, COORD_MAX, COORD_MAX, 0, MAX_T,
                    'h00FF00);
    send_pixel(COORD_MAX, COORD_MAX);
    finish_phase();
    // thick diagonal: full cross and clipped crosses in both corners
    setup_primitive(rpc_pkg::PRIM_THICK, 0, 0, COORD_MAX, COORD_MAX, 0, MAX_T, 'h123456);
    send_pixel(512, 512);
    send_pixel(COORD_MAX, COORD_MAX);
    send_pixel(0, 0);
    finish_phase();
    // reversed sloped line and reversed vertical line cover nothing
    setup_primitive(rpc_pkg::PRIM_LINE, 100, 100, 50, 200, 0, 0, 'hABCDEF);
    send_pixel(75, 150);
    finish_phase();
    setup_primitive(rpc_pkg::PRIM_LINE, 30, 500, 30, 100, 0, 0, 'hABCDEF);
    send_pixel(30, 300);
    finish_phase();
    // outline with top below bottom keeps only the two rows
    setup_primitive(rpc_pkg::PRIM_RECT, 10, 50, 60, 20, 0, 0, 'h0000FF);
    send_pixel(30, 50);
    send_pixel(10, 30);
    send_pixel(30, 20);
    send_pixel(60, 50);
    finish_phase();
    // full-frame filled rectangle corners
    setup_primitive(rpc_pkg::PRIM_FILL, 0, 0, COORD_MAX, COORD_MAX, 0, 0, 'hFF0000);
    send_pixel(0, 0);
    send_pixel(COORD_MAX, COORD_MAX);
    finish_phase();
    // ring band: inside, outer edge, hole
    setup_primitive(rpc_pkg::PRIM_RING, 512, 512, 0, 0, 10, 3, 'h808080);
    send_pixel(512, 521);
    send_pixel(512, 522);
    send_pixel(512, 517);
    finish_phase();
    // band wider than the radius still leaves a hole
    setup_primitive(rpc_pkg::PRIM_RING, 512, 512, 0, 0, 3, 10, 'h808080);
    send_pixel(512, 512);
    finish_phase();
    // unused primitive codes
    for (int code = 5; code <= 7; code++) begin
      setup_primitive(code, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX, MAX_T, 'hFFFFFF);
      send_pixel(100, 100);
      finish_phase();
    end
  endtask

  initial begin
    #RUN_LIMIT;
    $display("** raster_primitive_coverage: FAILED **");
    $finish;
  end

  initial begin
    int x, y;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    src_idle_pct  = 7;
    rx_idle_pct   = 79;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_checks();

    // random setups under three idle schedules
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES / 3) begin
        src_idle_pct = 79;
        rx_idle_pct  = 7;
      end
      if (p == 2 * RANDOM_PHASES / 3) begin
        src_idle_pct = 0;
        rx_idle_pct  = 0;
      end
      random_setup(p == 2);
      if (p == 2) hold_req <= ~hold_req;
      repeat (PHASE_ITEMS) begin
        pick_candidate(x, y);
        send_pixel(x, y);
      end
      finish_phase();
    end

    $display("Run covered %0d candidate pixels over %0d primitive setups, all eight codes,",
             candidates_sent, setups);
    $display("  %0d writes checked with clipping, reversed bounds and a long output stall.",
             board.writes_seen);
    if (board.errors == 0) begin
      $display("** raster_primitive_coverage: PASSED **");
    end else begin
      $display("** raster_primitive_coverage: FAILED **");
    end
    $finish;
  end

endmodule
